// ----- hw/rtl/tpc_pkg.sv -----
// shared types, constants and helpers for the temperature and pressure compensation block
package tpc_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_TEMP_T1     = 3'd0;
    localparam logic [2:0] REG_TEMP_T2_T3  = 3'd1;
    localparam logic [2:0] REG_PRESS_P1    = 3'd2;
    localparam logic [2:0] REG_PRESS_P2_P3 = 3'd3;
    localparam logic [2:0] REG_PRESS_P4_P5 = 3'd4;
    localparam logic [2:0] REG_PRESS_P6_P7 = 3'd5;
    localparam logic [2:0] REG_PRESS_P8_P9 = 3'd6;

    localparam int CFG_IDX_W = 3;
    localparam int QUO_W     = 32;

    localparam logic signed [31:0] PRESS_OFFSET = 32'sd64000;
    localparam logic [31:0]        RAW_FULL     = 32'd1048576;
    localparam logic [31:0]        PRESS_SCALE  = 32'd3125;
    localparam logic [31:0]        HALF_RANGE   = 32'h8000_0000;
    localparam logic signed [31:0] P1_BIAS      = 32'sd32768;
    localparam logic signed [31:0] ROUND_TEMP   = 32'sd128;

    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] temperature_centi_deg;
        logic [31:0]        pressure_pa;
        logic               pressure_valid;
    } out_word_t;

    typedef struct packed {
        logic [15:0]        t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic [15:0]        p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } calib_t;

    // wrapped 32-bit signed product
    function automatic logic signed [31:0] mul32(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [63:0] full;
        full = a * b;
        return full[31:0];
    endfunction

endpackage

// ----- hw/rtl/tpc_divider.sv -----
// pipelined restoring divider, one quotient bit per stage, with side payload
module tpc_divider #(
    parameter int SIDE_W = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  in_valid,
    input  logic [31:0]           dividend,
    input  logic [31:0]           divisor,
    input  logic [SIDE_W-1:0]     side_in,
    output logic                  out_valid,
    output logic [31:0]           quotient,
    output logic [SIDE_W-1:0]     side_out
);
    localparam int N = tpc_pkg::QUO_W;

    logic [N-1:0]      vld_reg;
    logic [31:0]       rem_reg   [N];
    logic [31:0]       quo_reg   [N];
    logic [31:0]       dvs_reg   [N];
    logic [SIDE_W-1:0] side_reg  [N];
    logic [31:0]       rem_src   [N];
    logic [31:0]       quo_src   [N];
    logic [31:0]       dvs_src   [N];
    logic [SIDE_W-1:0] side_src  [N];
    logic [32:0]       trial_rem [N];
    logic [32:0]       diff      [N];

    // stage inputs and one restoring trial per stage
    always_comb
    begin
        rem_src[0]  = 32'd0;
        quo_src[0]  = dividend;
        dvs_src[0]  = divisor;
        side_src[0] = side_in;
        for (int i = 1; i < N; i++)
        begin
            rem_src[i]  = rem_reg[i-1];
            quo_src[i]  = quo_reg[i-1];
            dvs_src[i]  = dvs_reg[i-1];
            side_src[i] = side_reg[i-1];
        end
        for (int i = 0; i < N; i++)
        begin
            trial_rem[i] = {rem_src[i], quo_src[i][31]};
            diff[i]      = trial_rem[i] - {1'b0, dvs_src[i]};
        end
    end

    // valid bits travel with the stages
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[N-2:0], in_valid};
    end

    // stage registers
    always_ff @(posedge clk) begin
        if (adv)
        begin
            for (int i = 0; i < N; i++)
            begin
                if (!diff[i][32])
                begin
                    rem_reg[i] <= diff[i][31:0];
                    quo_reg[i] <= {quo_src[i][30:0], 1'b1};
                end
                else
                begin
                    rem_reg[i] <= trial_rem[i][31:0];
                    quo_reg[i] <= {quo_src[i][30:0], 1'b0};
                end
                dvs_reg[i]  <= dvs_src[i];
                side_reg[i] <= side_src[i];
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign quotient  = quo_reg[N-1];
    assign side_out  = side_reg[N-1];
endmodule

// ----- hw/rtl/tpc_front.sv -----
// front stages: fine temperature, temperature, divisor and dividend terms
module tpc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_valid,
    input  tpc_pkg::in_word_t   in_word,
    input  tpc_pkg::calib_t     cal,
    output logic                out_valid,
    output logic signed [31:0]  temp_out,
    output logic [31:0]         dividend,
    output logic [31:0]         divisor,
    output logic                div_ok,
    output logic                div_dbl
);
    // stage 1 registers
    logic signed [31:0] s1_a_reg, s1_b_reg;
    logic [19:0]        s1_rp_reg;
    // stage 2
    logic signed [31:0] s2_m1_reg, s2_bb_reg;
    logic [19:0]        s2_rp_reg;
    // stage 3
    logic signed [31:0] s3_v1_reg, s3_m2_reg;
    logic [19:0]        s3_rp_reg;
    // stage 4
    logic signed [31:0] s4_tf_reg;
    logic [19:0]        s4_rp_reg;
    // stage 5
    logic signed [31:0] s5_t5_reg, s5_pv1_reg, s5_sq_reg;
    logic [19:0]        s5_rp_reg;
    // stage 6
    logic signed [31:0] s6_temp_reg, s6_a_reg, s6_b_reg, s6_c_reg, s6_d_reg;
    logic signed [31:0] s6_e_reg;
    logic [19:0]        s6_rp_reg;
    // stage 7
    logic signed [31:0] s7_temp_reg, s7_v2_reg, s7_v1_reg;
    logic [19:0]        s7_rp_reg;
    // stage 8
    logic signed [31:0] s8_temp_reg, s8_v2_reg, s8_x_reg;
    logic [19:0]        s8_rp_reg;
    // stage 9
    logic signed [31:0] s9_temp_reg, s9_div_reg;
    logic [31:0]        s9_p_reg;

    logic [8:0] v_reg;

    logic signed [31:0] rt, rp_s, t1s;
    logic signed [31:0] q_next, v2a, t_sum, x_next, div_next, v2_sh;
    logic [31:0]        p_base;

    assign rt  = {12'd0, in_word.raw_temperature};
    assign t1s = {16'd0, cal.t1};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[7:0], in_valid};
    end

    // pressure divisor and dividend terms
    always_comb
    begin
        q_next   = s5_pv1_reg >>> 2;
        v2a      = s6_a_reg + s6_b_reg;
        t_sum    = (s7_v2_reg >>> 2) + s6_e_reg;
        rp_s     = {12'd0, s8_rp_reg};
        v2_sh    = s8_v2_reg >>> 12;
        p_base   = (tpc_pkg::RAW_FULL - rp_s) - v2_sh;
        x_next   = tpc_pkg::mul32(tpc_pkg::P1_BIAS + s8_x_reg, {16'd0, cal.p1});
        div_next = x_next >>> 15;
    end

    always_ff @(posedge clk) begin
        if (adv)
        begin
            // stage 1
            s1_a_reg  <= (rt >>> 3) - (t1s <<< 1);
            s1_b_reg  <= (rt >>> 4) - t1s;
            s1_rp_reg <= in_word.raw_pressure;
            // stage 2
            s2_m1_reg <= tpc_pkg::mul32(s1_a_reg, 32'(cal.t2));
            s2_bb_reg <= tpc_pkg::mul32(s1_b_reg, s1_b_reg);
            s2_rp_reg <= s1_rp_reg;
            // stage 3
            s3_v1_reg <= s2_m1_reg >>> 11;
            s3_m2_reg <= tpc_pkg::mul32(s2_bb_reg >>> 12, 32'(cal.t3));
            s3_rp_reg <= s2_rp_reg;
            // stage 4
            s4_tf_reg <= s3_v1_reg + (s3_m2_reg >>> 14);
            s4_rp_reg <= s3_rp_reg;
            // stage 5
            s5_t5_reg  <= tpc_pkg::mul32(s4_tf_reg, 32'sd5) + tpc_pkg::ROUND_TEMP;
            s5_pv1_reg <= (s4_tf_reg >>> 1) - tpc_pkg::PRESS_OFFSET;
            s5_sq_reg  <= (s4_tf_reg >>> 1) - tpc_pkg::PRESS_OFFSET;
            s5_rp_reg  <= s4_rp_reg;
            // stage 6: square of v1/4 and the v1 products
            s6_temp_reg <= s5_t5_reg >>> 8;
            s6_a_reg    <= tpc_pkg::mul32(q_next, q_next);
            s6_b_reg    <= '0;
            s6_c_reg    <= tpc_pkg::mul32(s5_pv1_reg, 32'(cal.p5)) <<< 1;
            s6_d_reg    <= tpc_pkg::mul32(32'(cal.p2), s5_sq_reg) >>> 1;
            s6_e_reg    <= 32'(cal.p4) <<< 16;
            s6_rp_reg   <= s5_rp_reg;
            // stage 7
            s7_temp_reg <= s6_temp_reg;
            s7_v2_reg   <= tpc_pkg::mul32(v2a >>> 11, 32'(cal.p6)) + s6_c_reg;
            s7_v1_reg   <= (tpc_pkg::mul32(32'(cal.p3), v2a >>> 13) >>> 3) + s6_d_reg;
            s7_rp_reg   <= s6_rp_reg;
            // stage 8
            s8_temp_reg <= s7_temp_reg;
            s8_v2_reg   <= t_sum;
            s8_x_reg    <= s7_v1_reg >>> 18;
            s8_rp_reg   <= s7_rp_reg;
            // stage 9
            s9_temp_reg <= s8_temp_reg;
            s9_div_reg  <= div_next;
            s9_p_reg    <= p_base * tpc_pkg::PRESS_SCALE;
        end
    end

    assign out_valid = v_reg[8];
    assign temp_out  = s9_temp_reg;
    assign divisor   = s9_div_reg;
    assign div_ok    = (s9_div_reg != 32'sd0);
    assign div_dbl   = (s9_p_reg >= tpc_pkg::HALF_RANGE);
    assign dividend  = (s9_p_reg < tpc_pkg::HALF_RANGE) ? {s9_p_reg[30:0], 1'b0} : s9_p_reg;
endmodule

// ----- hw/rtl/tpc_back.sv -----
// back stages: divide fix-up and final pressure correction
module tpc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_valid,
    input  logic [31:0]        quotient,
    input  logic               dbl,
    input  logic               div_ok,
    input  logic signed [31:0] temp_in,
    input  tpc_pkg::calib_t    cal,
    output logic               out_valid,
    output tpc_pkg::out_word_t out_word
);
    logic [2:0]         v_reg;
    logic [31:0]        b1_p_reg, b2_p_reg, b3_p_reg;
    logic               b1_ok_reg, b2_ok_reg, b3_ok_reg;
    logic signed [31:0] b1_t_reg, b2_t_reg, b3_t_reg;
    logic [31:0]        b1_sq_reg;
    logic signed [31:0] b2_v1_reg, b2_v2_reg;
    logic signed [31:0] b3_c_reg;
    logic [31:0]        p_fix, p3;
    logic [31:0]        sq_lo;
    logic signed [31:0] sum;

    // square of p/8 wraps at 32 bits
    assign p_fix   = dbl ? {quotient[30:0], 1'b0} : quotient;
    assign p3      = p_fix >> 3;
    assign sq_lo   = p3 * p3;
    assign sum     = b2_v1_reg + b2_v2_reg + 32'(cal.p7);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[1:0], in_valid};
    end

    always_ff @(posedge clk) begin
        if (adv)
        begin
            b1_p_reg  <= p_fix;
            b1_sq_reg <= {13'd0, sq_lo[31:13]};
            b1_ok_reg <= div_ok;
            b1_t_reg  <= temp_in;
            b2_p_reg  <= b1_p_reg;
            b2_v1_reg <= tpc_pkg::mul32(32'(cal.p9), b1_sq_reg) >>> 12;
            b2_v2_reg <= tpc_pkg::mul32({2'b00, b1_p_reg[31:2]}, 32'(cal.p8)) >>> 13;
            b2_ok_reg <= b1_ok_reg;
            b2_t_reg  <= b1_t_reg;
            b3_c_reg  <= sum >>> 4;
            b3_p_reg  <= b2_p_reg;
            b3_ok_reg <= b2_ok_reg;
            b3_t_reg  <= b2_t_reg;
        end
    end

    assign out_valid                = v_reg[2];
    assign out_word.temperature_centi_deg = b3_t_reg;
    assign out_word.pressure_pa     = b3_ok_reg ? (b3_p_reg + b3_c_reg) : 32'd0;
    assign out_word.pressure_valid  = b3_ok_reg;
endmodule

// ----- hw/rtl/temp_pressure_compensation_top.sv -----
// top level of the temperature and pressure compensation pipeline
// Usage: raw temperature and pressure words enter on in_valid/in_stall; the
// compensated temperature, pressure and pressure_valid leave on out_valid/
// out_stall. Calibration is loaded through cfg_valid/cfg_ready with cfg_index
// and cfg_data; the user must load it only while no word is in flight, and
// the block itself does not enforce it. cfg_ready is always high. The pipeline
// has front arithmetic, 32 divider stages (one quotient bit each) and 3
// correction stages. One word per cycle when not held (fully pipelined divider).
// When the receiver stalls, the waiting word is parked in an output register;
// from the next cycle in_stall is high and the whole pipeline holds until
// that word leaves, so in_stall never depends on out_stall in the same cycle.
// Bubbles are not squeezed out: a held pipeline stalls the input even when
// some stages are empty.
// Reset clears all valid bits and all calibration registers to zero.
module temp_pressure_compensation_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  tpc_pkg::in_word_t     in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output tpc_pkg::out_word_t    out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [tpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]           cfg_data
);
    logic [15:0] t1_reg, p1_reg;
    logic [31:0] t23_reg, p23_reg, p45_reg, p67_reg, p89_reg;
    tpc_pkg::calib_t cal;
    logic adv;
    logic f_valid, f_ok, f_dbl, d_valid;
    logic signed [31:0] f_temp;
    logic [31:0] f_dividend, f_divisor, d_quo;
    logic [33:0] d_side;
    logic p_valid;
    tpc_pkg::out_word_t p_word;
    logic skid_valid_reg;
    tpc_pkg::out_word_t skid_word_reg;

    assign cfg_ready = 1'b1;

    // calibration registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            t1_reg <= '0; t23_reg <= '0; p1_reg <= '0; p23_reg <= '0;
            p45_reg <= '0; p67_reg <= '0; p89_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tpc_pkg::REG_TEMP_T1:     t1_reg  <= cfg_data[15:0];
                tpc_pkg::REG_TEMP_T2_T3:  t23_reg <= cfg_data;
                tpc_pkg::REG_PRESS_P1:    p1_reg  <= cfg_data[15:0];
                tpc_pkg::REG_PRESS_P2_P3: p23_reg <= cfg_data;
                tpc_pkg::REG_PRESS_P4_P5: p45_reg <= cfg_data;
                tpc_pkg::REG_PRESS_P6_P7: p67_reg <= cfg_data;
                tpc_pkg::REG_PRESS_P8_P9: p89_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cal = '{t1: t1_reg, t2: t23_reg[15:0], t3: t23_reg[31:16],
                   p1: p1_reg, p2: p23_reg[15:0], p3: p23_reg[31:16],
                   p4: p45_reg[15:0], p5: p45_reg[31:16],
                   p6: p67_reg[15:0], p7: p67_reg[31:16],
                   p8: p89_reg[15:0], p9: p89_reg[31:16]};

    // global advance: move unless a word is parked in the output register
    assign adv      = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    // output register catches a stalled word so the pipeline can hold
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            skid_valid_reg <= 1'b0;
        else if (skid_valid_reg)
        begin
            if (!out_stall)
                skid_valid_reg <= 1'b0;
        end
        else if (p_valid && out_stall)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk) begin
        if (!skid_valid_reg && p_valid && out_stall)
            skid_word_reg <= p_word;
    end

    assign out_valid = skid_valid_reg || p_valid;
    assign out_data  = skid_valid_reg ? skid_word_reg : p_word;

    tpc_front u_front (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .in_valid(in_valid), .in_word(in_data), .cal(cal),
        .out_valid(f_valid), .temp_out(f_temp), .dividend(f_dividend),
        .divisor(f_divisor), .div_ok(f_ok), .div_dbl(f_dbl)
    );

    tpc_divider #(.SIDE_W(34)) u_div (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .in_valid(f_valid), .dividend(f_dividend),
        .divisor(f_ok ? f_divisor : 32'd1),
        .side_in({f_temp, f_ok, f_dbl}),
        .out_valid(d_valid), .quotient(d_quo), .side_out(d_side)
    );

    tpc_back u_back (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .in_valid(d_valid), .quotient(d_quo), .dbl(d_side[0]),
        .div_ok(d_side[1]), .temp_in(d_side[33:2]), .cal(cal),
        .out_valid(p_valid), .out_word(p_word)
    );

    // a held output word keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output word changed while stalled");

    // a zero divisor reports zero pressure
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.pressure_valid |-> out_data.pressure_pa == 32'd0)
        else $error("pressure not zero on invalid divisor");

    // input stall only while a parked word is offered
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled without a parked output word");
endmodule

// ----- tb/tpc_compensation_check.sv -----
// watches the channels of the compensation block, predicts each result and compares
module tpc_compensation_check (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  tpc_pkg::in_word_t             in_data,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  tpc_pkg::out_word_t            out_data,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [tpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,
    output int                            errors,
    output int                            pending
);

    // shadow of the calibration registers
    logic [15:0] cal_t1;
    logic [31:0] cal_t2_t3;
    logic [15:0] cal_p1;
    logic [31:0] cal_p2_p3;
    logic [31:0] cal_p4_p5;
    logic [31:0] cal_p6_p7;
    logic [31:0] cal_p8_p9;

    tpc_pkg::out_word_t compensated_q[$];

    // 32-bit wrapped integer compensation
    function automatic tpc_pkg::out_word_t compensate(tpc_pkg::in_word_t w);
        int t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        int rt, rp, a, b, v1, v2, tf, temp, q, sq;
        logic [31:0] p, dv, p3s;
        tpc_pkg::out_word_t r;
        t1 = int'({16'b0, cal_t1});
        t2 = int'($signed(cal_t2_t3[15:0]));
        t3 = int'($signed(cal_t2_t3[31:16]));
        p1 = int'({16'b0, cal_p1});
        p2 = int'($signed(cal_p2_p3[15:0]));
        p3 = int'($signed(cal_p2_p3[31:16]));
        p4 = int'($signed(cal_p4_p5[15:0]));
        p5 = int'($signed(cal_p4_p5[31:16]));
        p6 = int'($signed(cal_p6_p7[15:0]));
        p7 = int'($signed(cal_p6_p7[31:16]));
        p8 = int'($signed(cal_p8_p9[15:0]));
        p9 = int'($signed(cal_p8_p9[31:16]));
        rt = int'({12'b0, w.raw_temperature});
        rp = int'({12'b0, w.raw_pressure});

        // fine temperature and degrees
        a  = (rt >>> 3) - t1 * 2;
        b  = (rt >>> 4) - t1;
        v1 = (a * t2) >>> 11;
        v2 = (((b * b) >>> 12) * t3) >>> 14;
        tf = v1 + v2;
        temp = (tf * 5 + 128) >>> 8;

        // pressure divisor and dividend terms
        v1 = (tf >>> 1) - 64000;
        q  = v1 >>> 2;
        sq = q * q;
        v2 = (sq >>> 11) * p6;
        v2 = v2 + (v1 * p5) * 2;
        v2 = (v2 >>> 2) + p4 * 65536;
        v1 = (((p3 * (sq >>> 13)) >>> 3) + ((p2 * v1) >>> 1)) >>> 18;
        v1 = ((32768 + v1) * p1) >>> 15;

        r.temperature_centi_deg = temp;
        if (v1 == 0)
        begin
            r.pressure_pa    = '0;
            r.pressure_valid = 1'b0;
        end
        else
        begin
            dv = v1;
            p  = (32'(1048576 - rp) - 32'(v2 >>> 12)) * 32'd3125;
            // large dividend is divided before doubling
            if (p < 32'h8000_0000)
                p = (p << 1) / dv;
            else
                p = (p / dv) * 32'd2;
            p3s = (p >> 3) * (p >> 3);
            v1 = (p9 * int'(p3s >> 13)) >>> 12;
            v2 = (int'(p >> 2) * p8) >>> 13;
            p  = p + 32'((v1 + v2 + p7) >>> 4);
            r.pressure_pa    = p;
            r.pressure_valid = 1'b1;
        end
        return r;
    endfunction

    assign pending = compensated_q.size();

    // register writes, accepted words and results
    always @(posedge clk or negedge rst_n)
    begin
        tpc_pkg::out_word_t want;
        int bad;
        bad = 0;
        if (!rst_n)
        begin
            cal_t1    <= '0;
            cal_t2_t3 <= '0;
            cal_p1    <= '0;
            cal_p2_p3 <= '0;
            cal_p4_p5 <= '0;
            cal_p6_p7 <= '0;
            cal_p8_p9 <= '0;
            errors    <= 0;
            compensated_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    tpc_pkg::REG_TEMP_T1:     cal_t1    <= cfg_data[15:0];
                    tpc_pkg::REG_TEMP_T2_T3:  cal_t2_t3 <= cfg_data;
                    tpc_pkg::REG_PRESS_P1:    cal_p1    <= cfg_data[15:0];
                    tpc_pkg::REG_PRESS_P2_P3: cal_p2_p3 <= cfg_data;
                    tpc_pkg::REG_PRESS_P4_P5: cal_p4_p5 <= cfg_data;
                    tpc_pkg::REG_PRESS_P6_P7: cal_p6_p7 <= cfg_data;
                    tpc_pkg::REG_PRESS_P8_P9: cal_p8_p9 <= cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                compensated_q.push_back(compensate(in_data));
            if (out_valid && !out_stall)
            begin
                if (compensated_q.size() == 0)
                begin
                    $display("%0t: result word expected none actual %h", $time, out_data);
                    bad++;
                end
                else
                begin
                    want = compensated_q.pop_front();
                    if (want.temperature_centi_deg !== out_data.temperature_centi_deg)
                    begin
                        $display("%0t: temperature expected %0d actual %0d", $time,
                                 want.temperature_centi_deg, out_data.temperature_centi_deg);
                        bad++;
                    end
                    if (want.pressure_pa !== out_data.pressure_pa)
                    begin
                        $display("%0t: pressure expected %0d actual %0d", $time,
                                 want.pressure_pa, out_data.pressure_pa);
                        bad++;
                    end
                    if (want.pressure_valid !== out_data.pressure_valid)
                    begin
                        $display("%0t: pressure_valid expected %b actual %b", $time,
                                 want.pressure_valid, out_data.pressure_valid);
                        bad++;
                    end
                end
            end
            if (bad != 0)
                errors <= errors + bad;
        end
    end

endmodule

// ----- tb/temp_pressure_compensation_top_test.sv -----
// stimulus and verdict for the temperature and pressure compensation block
module temp_pressure_compensation_top_test;

    localparam logic [tpc_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 60;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    tpc_pkg::in_word_t             in_data;
    logic                          out_valid;
    logic                          out_stall;
    tpc_pkg::out_word_t            out_data;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [tpc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [31:0]                   cfg_data;
    int                            errors;
    int                            pending;
    int                            cycles;
    bit                            hold_long;
    bit                            no_gaps;

    temp_pressure_compensation_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    tpc_compensation_check check (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("temp_pressure_compensation_top_test: errors");
                $finish;
            end
        end
    end

    // receiver: random stalls per word, one long hold when asked
    initial
    begin
        int n;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            if (hold_long)
            begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                hold_long = 1'b0;
            end
            n = no_gaps ? 0 : $urandom_range(0, 13);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic write_reg(logic [tpc_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_calibration(logic [15:0] t1, logic [31:0] t23, logic [15:0] p1,
                                    logic [31:0] p23, logic [31:0] p45,
                                    logic [31:0] p67, logic [31:0] p89);
        write_reg(tpc_pkg::REG_TEMP_T1, {16'($urandom_range(0, 65535)), t1});
        write_reg(tpc_pkg::REG_TEMP_T2_T3, t23);
        write_reg(tpc_pkg::REG_PRESS_P1, {16'($urandom_range(0, 65535)), p1});
        write_reg(tpc_pkg::REG_PRESS_P2_P3, p23);
        write_reg(tpc_pkg::REG_PRESS_P4_P5, p45);
        write_reg(tpc_pkg::REG_PRESS_P6_P7, p67);
        write_reg(tpc_pkg::REG_PRESS_P8_P9, p89);
    endtask

    task automatic send_word(logic [19:0] rt, logic [19:0] rp);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_data  <= '{raw_temperature: rt, raw_pressure: rp};
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
    endtask

    // block goes idle: no word expected and pipeline drained
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_words(int count);
        repeat (count)
        begin
            if ($urandom_range(0, 39) == 0)
                no_gaps = ~no_gaps;
            case ($urandom_range(0, 3))
                0: send_word($urandom_range(0, 1) ? 20'h0 : 20'hFFFFF, 20'($urandom));
                1: send_word(20'(519888 + $urandom_range(0, 20000) - 10000),
                             20'(415148 + $urandom_range(0, 100000) - 50000));
                default: send_word(20'($urandom), 20'($urandom));
            endcase
        end
    endtask

    initial
    begin
        logic [19:0] edge_vals[4];
        edge_vals = '{20'h0, 20'h1, 20'h80000, 20'hFFFFF};
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        hold_long = 1'b0;
        no_gaps   = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset calibration: divisor is zero, pressure flagged invalid
        foreach (edge_vals[i]) send_word(edge_vals[i], edge_vals[3 - i]);
        drain();

        // typical factory calibration, extremes of the readings
        load_calibration(16'd27504, {16'hFC18, 16'd26435}, 16'd36477,
                         {16'd3024, 16'hD643}, {16'd140, 16'd2855},
                         {16'd15500, 16'hFFF9}, {16'd6000, 16'hC708});
        write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
        foreach (edge_vals[i])
            foreach (edge_vals[j]) send_word(edge_vals[i], edge_vals[j]);
        send_word(20'd519888, 20'd415148);
        drain();

        // extreme calibrations
        load_calibration(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        foreach (edge_vals[i]) send_word(edge_vals[i], edge_vals[i]);
        drain();
        load_calibration(16'h8000, 32'h8000_8000, 16'h8000, 32'h7FFF_7FFF,
                         32'h8000_7FFF, 32'h7FFF_8000, 32'h8000_8000);
        foreach (edge_vals[i]) send_word(edge_vals[i], edge_vals[3 - i]);
        drain();

        // random phases, with a long receiver hold in the first
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph % 3 == 2)
                load_calibration(16'($urandom), $urandom, 16'($urandom), $urandom,
                                 $urandom, $urandom, $urandom);
            else
                load_calibration(16'(27504 + $urandom_range(0, 2000)),
                                 {16'hFC18 + 16'($urandom_range(0, 600)),
                                  16'd26000 + 16'($urandom_range(0, 900))},
                                 16'd36000 + 16'($urandom_range(0, 1000)),
                                 {16'd3000 + 16'($urandom_range(0, 50)),
                                  16'hD643 + 16'($urandom_range(0, 200))},
                                 {16'd140 + 16'($urandom_range(0, 20)),
                                  16'd2855 + 16'($urandom_range(0, 100))},
                                 {16'd15500 + 16'($urandom_range(0, 100)),
                                  16'hFFF9 + 16'($urandom_range(0, 10))},
                                 {16'd6000 + 16'($urandom_range(0, 100)),
                                  16'hC708 + 16'($urandom_range(0, 100))});
            if (ph == 0)
                hold_long = 1'b1;
            random_words(240);
            drain();
        end
        // zero pressure scale after the phases gives an invalid run too
        write_reg(tpc_pkg::REG_PRESS_P1, 32'h0);
        random_words(20);
        drain();

        if (errors == 0)
            $display("temp_pressure_compensation_top_test: clean");
        else
            $display("temp_pressure_compensation_top_test: errors");
        $finish;
    end

endmodule
